FILE: rtl/core/frc_pkg.sv
// Shared types, register indexes and constants of the framed command receiver.
package frc_pkg;

    // Default payload buffer depth in bytes
    localparam int BUFFER_DEPTH_DEF = 32;

    // Longest run of result items one frame can produce
    localparam int MAX_RUN = 32;

    // Width of the byte position field
    localparam int POS_W = 5;

    // Configuration register index port width
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_ID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY_ID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY_LENGTH = 3'd4;

    // Register reset values
    localparam logic [7:0] START_BYTE_RST   = 8'd170;
    localparam logic [7:0] SERVO_ID_RST     = 8'd1;
    localparam logic [5:0] SERVO_LENGTH_RST = 6'd4;
    localparam logic [7:0] RELAY_ID_RST     = 8'd2;
    localparam logic [5:0] RELAY_LENGTH_RST = 6'd1;

    // Frame kinds
    localparam logic KIND_SERVO = 1'b0;
    localparam logic KIND_RELAY = 1'b1;

    // Parser and emission states
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ID,
        ST_LEN,
        ST_PAYLOAD,
        ST_CHECK,
        ST_READ,
        ST_SEND
    } frc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_id;
        logic load_len;
        logic store_byte;
        logic load_run;
        logic rd_first;
        logic rd_next;
        logic load_out;
    } frc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic start_hit;
        logic len_ok;
        logic fill_done;
        logic frame_ok;
        logic run_last;
        logic out_free;
    } frc_sts_t;

endpackage

FILE: rtl/core/framed_command_receiver.sv
// Top level of the framed command receiver: controller, datapath and checks.
//
//  Channel   Ports                                           Direction
//  input     s_valid s_ready s_rx_byte                        byte requests in
//  result    m_valid m_ready m_frame_kind m_payload_byte      payload requests out
//            m_byte_position m_last_byte
//  config    cfg_valid cfg_ready cfg_index cfg_data           register writes in
//
// Input bytes are taken one per cycle while a frame is parsed and checked.
// After a good checksum input stops while the payload buffer (at most BUFFER_DEPTH
// bytes) is read out through its registered read port, one byte a cycle while the
// result side takes them. Reset is synchronous and active low; the buffer needs no
// clearing. Config writes are always taken.
module framed_command_receiver #(
    parameter int BUFFER_DEPTH = frc_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_frame_kind,
    output logic [7:0]                    m_payload_byte,
    output logic [frc_pkg::POS_W-1:0]     m_byte_position,
    output logic                          m_last_byte
);

    frc_pkg::frc_cmd_t   cmd;
    frc_pkg::frc_sts_t   sts;
    frc_pkg::frc_state_t ctrl_state;

    assign cfg_ready = 1'b1;

    frc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .state   (ctrl_state)
    );

    frc_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_rx_byte       (s_rx_byte),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_frame_kind    (m_frame_kind),
        .m_payload_byte  (m_payload_byte),
        .m_byte_position (m_byte_position),
        .m_last_byte     (m_last_byte),
        .cmd             (cmd),
        .sts             (sts)
    );

    // Input only stops to start a payload run
    a_stop_for_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> ctrl_state == frc_pkg::ST_READ)
        else $error("input stalled outside a payload run");

    // Nothing follows the last byte of a run straight away unless a new run is waiting
    a_quiet_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_byte && (ctrl_state != frc_pkg::ST_SEND) |=> !m_valid)
        else $error("result request after the last byte of a run");

    // Each run opens at position zero
    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> m_byte_position == '0)
        else $error("run did not start at position zero");

endmodule

FILE: rtl/core/frc_ram.sv
// Generic single write port RAM with a registered read port.
module frc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/frc_ctrl.sv
// Controller state machine: frame parsing phases and payload emission sequencing.
module frc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  frc_pkg::frc_sts_t   sts,
    output frc_pkg::frc_cmd_t   cmd,
    output frc_pkg::frc_state_t state
);

    frc_pkg::frc_state_t state_reg;
    frc_pkg::frc_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frc_pkg::ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            frc_pkg::ST_HUNT: begin
                s_ready = 1'b1;
                if (s_valid && sts.start_hit) begin
                    state_next = frc_pkg::ST_ID;
                end
            end
            frc_pkg::ST_ID: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_id = 1'b1;
                    state_next  = frc_pkg::ST_LEN;
                end
            end
            frc_pkg::ST_LEN: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_len = 1'b1;
                    state_next   = sts.len_ok ? frc_pkg::ST_PAYLOAD : frc_pkg::ST_HUNT;
                end
            end
            frc_pkg::ST_PAYLOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store_byte = 1'b1;
                    if (sts.fill_done) begin
                        state_next = frc_pkg::ST_CHECK;
                    end
                end
            end
            frc_pkg::ST_CHECK: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts.frame_ok) begin
                        cmd.load_run = 1'b1;
                        state_next   = frc_pkg::ST_READ;
                    end else begin
                        state_next = frc_pkg::ST_HUNT;
                    end
                end
            end
            frc_pkg::ST_READ: begin
                // first buffer read of the run
                cmd.rd_first = 1'b1;
                state_next   = frc_pkg::ST_SEND;
            end
            frc_pkg::ST_SEND: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    if (sts.run_last) begin
                        state_next = frc_pkg::ST_HUNT;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = frc_pkg::ST_HUNT;
            end
        endcase
    end

    assign state = state_reg;

endmodule

FILE: rtl/core/frc_datapath.sv
// Datapath: configuration registers, frame fields, checksum, payload buffer, output register.
module frc_datapath #(
    parameter int BUFFER_DEPTH = frc_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [frc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic [7:0]                     s_rx_byte,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic                           m_frame_kind,
    output logic [7:0]                     m_payload_byte,
    output logic [frc_pkg::POS_W-1:0]      m_byte_position,
    output logic                           m_last_byte,
    input  frc_pkg::frc_cmd_t              cmd,
    output frc_pkg::frc_sts_t              sts
);

    localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W  = (LEN_W > 6) ? LEN_W : 6;
    localparam int CMP_W  = (LEN_W > 6) ? LEN_W : 6;

    // Configuration registers
    logic [7:0] start_byte_reg;
    logic [7:0] servo_id_reg;
    logic [5:0] servo_length_reg;
    logic [7:0] relay_id_reg;
    logic [5:0] relay_length_reg;

    // Frame state
    logic [7:0]       command_id_reg;
    logic [LEN_W-1:0] exp_len_reg;
    logic [LEN_W-1:0] fill_pos_reg;
    logic [LEN_W-1:0] fill_pos_next;
    logic [7:0]       xor_reg;

    // Emission state
    logic             kind_reg;
    logic [CNT_W-1:0] run_len_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;

    // Output register
    logic                      out_valid_reg;
    logic                      out_kind_reg;
    logic [7:0]                out_byte_reg;
    logic [frc_pkg::POS_W-1:0] out_pos_reg;
    logic                      out_last_reg;

    logic              servo_hit;
    logic              relay_hit;
    logic [CNT_W-1:0]  len_cnt;
    logic [CNT_W-1:0]  run_len;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg   <= frc_pkg::START_BYTE_RST;
            servo_id_reg     <= frc_pkg::SERVO_ID_RST;
            servo_length_reg <= frc_pkg::SERVO_LENGTH_RST;
            relay_id_reg     <= frc_pkg::RELAY_ID_RST;
            relay_length_reg <= frc_pkg::RELAY_LENGTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                frc_pkg::REG_START_BYTE:   start_byte_reg   <= cfg_data;
                frc_pkg::REG_SERVO_ID:     servo_id_reg     <= cfg_data;
                frc_pkg::REG_SERVO_LENGTH: servo_length_reg <= cfg_data[5:0];
                frc_pkg::REG_RELAY_ID:     relay_id_reg     <= cfg_data;
                frc_pkg::REG_RELAY_LENGTH: relay_length_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Frame matching against the servo and relay settings (servo wins)
    assign servo_hit = (command_id_reg == servo_id_reg)
                    && (CMP_W'(exp_len_reg) == CMP_W'(servo_length_reg));
    assign relay_hit = (command_id_reg == relay_id_reg)
                    && (CMP_W'(exp_len_reg) == CMP_W'(relay_length_reg));

    // Run length is the frame length, capped at the longest run
    assign len_cnt = CNT_W'(exp_len_reg);
    assign run_len = (len_cnt > CNT_W'(frc_pkg::MAX_RUN)) ? CNT_W'(frc_pkg::MAX_RUN) : len_cnt;

    assign fill_pos_next = fill_pos_reg + LEN_W'(1);
    assign rd_idx_next   = rd_idx_reg + CNT_W'(1);

    // Status towards the controller
    always_comb begin
        sts.start_hit = (s_rx_byte == start_byte_reg);
        sts.len_ok    = (s_rx_byte != 8'd0) && (s_rx_byte <= 8'(BUFFER_DEPTH));
        sts.fill_done = (fill_pos_next == exp_len_reg);
        sts.frame_ok  = (s_rx_byte == xor_reg) && (servo_hit || relay_hit);
        sts.run_last  = (rd_idx_next == run_len_reg);
        sts.out_free  = !out_valid_reg || m_ready;
    end

    // Header fields, fill position and running checksum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_id_reg <= '0;
            exp_len_reg    <= '0;
            fill_pos_reg   <= '0;
            xor_reg        <= '0;
        end else begin
            if (cmd.load_id) begin
                command_id_reg <= s_rx_byte;
            end
            if (cmd.load_len) begin
                exp_len_reg  <= s_rx_byte[LEN_W-1:0];
                fill_pos_reg <= '0;
                xor_reg      <= '0;
            end
            if (cmd.store_byte) begin
                fill_pos_reg <= fill_pos_next;
                xor_reg      <= xor_reg ^ s_rx_byte;
            end
        end
    end

    // Run set-up and read index
    always_ff @(posedge aclk) begin
        if (cmd.load_run) begin
            kind_reg    <= servo_hit ? frc_pkg::KIND_SERVO : frc_pkg::KIND_RELAY;
            run_len_reg <= run_len;
            rd_idx_reg  <= '0;
        end else if (cmd.load_out) begin
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Payload buffer
    assign ram_rd_en   = cmd.rd_first || cmd.rd_next;
    assign ram_rd_addr = cmd.rd_first ? rd_idx_reg[ADDR_W-1:0] : rd_idx_next[ADDR_W-1:0];

    frc_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (cmd.store_byte),
        .wr_addr (fill_pos_reg[ADDR_W-1:0]),
        .wr_data (s_rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_kind_reg <= kind_reg;
            out_byte_reg <= ram_rd_data;
            out_pos_reg  <= rd_idx_reg[frc_pkg::POS_W-1:0];
            out_last_reg <= sts.run_last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_kind    = out_kind_reg;
    assign m_payload_byte  = out_byte_reg;
    assign m_byte_position = out_pos_reg;
    assign m_last_byte     = out_last_reg;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench of the framed command receiver: directed and random byte streams.
module testbench;

    localparam int DEPTH         = frc_pkg::BUFFER_DEPTH_DEF;
    localparam int IDX_BITS      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BYTES  = 120;
    localparam int PHASE_BYTES   = 24;
    localparam int MAX_PHASES    = 24;
    localparam int HOLD_CYCLES   = 300;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_MOSTLY
    } rx_pattern_t;

    // One payload byte as the result channel carries it
    typedef struct packed {
        logic                      kind;
        logic [7:0]                data;
        logic [frc_pkg::POS_W-1:0] pos;
        logic                      last;
    } payload_result_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [frc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                    cfg_data  = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_rx_byte = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic                          m_frame_kind;
    logic [7:0]                    m_payload_byte;
    logic [frc_pkg::POS_W-1:0]     m_byte_position;
    logic                          m_last_byte;

    // Byte requests still to be offered, and payload bytes still owed by the block
    logic [7:0]      pending_bytes[$];
    payload_result_t expected_payload[$];

    // Shadow registers
    logic [7:0] cur_start     = frc_pkg::START_BYTE_RST;
    logic [7:0] cur_servo_id  = frc_pkg::SERVO_ID_RST;
    logic [5:0] cur_servo_len = frc_pkg::SERVO_LENGTH_RST;
    logic [7:0] cur_relay_id  = frc_pkg::RELAY_ID_RST;
    logic [5:0] cur_relay_len = frc_pkg::RELAY_LENGTH_RST;

    // Shadow parser state
    frc_pkg::frc_state_t parse_state = frc_pkg::ST_HUNT;
    logic [7:0] frame_id    = '0;
    logic [5:0] frame_len   = '0;
    logic [5:0] fill_pos    = '0;
    logic [7:0] frame_xor   = '0;
    logic [7:0] frame_store [0:DEPTH-1];

    int error_count    = 0;
    int bytes_accepted = 0;
    int results_seen   = 0;
    int frames_seen    = 0;
    int settings_used  = 1;
    int random_bytes   = 0;

    // Directed stream under the reset settings
    logic [7:0] directed_bytes [0:25] = '{
        8'h00, 8'hFF,                                       // noise while hunting
        8'hAA, 8'h02, 8'h01, 8'hFF, 8'hFF,                  // relay, one byte
        8'hAA, 8'h01, 8'h04, 8'h00, 8'hAA, 8'h55, 8'hFF,    // servo, start byte inside
        8'h00,
        8'hAA, 8'h01, 8'h00,                                // zero length
        8'hAA, 8'h01, 8'h21,                                // length above the buffer
        8'hAA, 8'h02, 8'h01, 8'h05, 8'h04                   // bad checksum
    };

    framed_command_receiver uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_kind    (m_frame_kind),
        .m_payload_byte  (m_payload_byte),
        .m_byte_position (m_byte_position),
        .m_last_byte     (m_last_byte)
    );

    // Clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Mismatch reporting
    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    // Frame parser prediction: one accepted byte, payload results queued on a good frame
    task automatic parse_byte(input logic [7:0] b);
        logic found;
        logic kind;
        int   run_len;
        payload_result_t r;
        found = 1'b0;
        kind  = frc_pkg::KIND_SERVO;
        case (parse_state)
            frc_pkg::ST_HUNT: begin
                if (b == cur_start)
                    parse_state = frc_pkg::ST_ID;
            end
            frc_pkg::ST_ID: begin
                frame_id    = b;
                parse_state = frc_pkg::ST_LEN;
            end
            frc_pkg::ST_LEN: begin
                fill_pos  = '0;
                frame_xor = '0;
                frame_len = b[5:0];
                if (b != 8'd0 && int'(b) <= DEPTH)
                    parse_state = frc_pkg::ST_PAYLOAD;
                else
                    parse_state = frc_pkg::ST_HUNT;
            end
            frc_pkg::ST_PAYLOAD: begin
                if (int'(fill_pos) < DEPTH)
                    frame_store[fill_pos[IDX_BITS-1:0]] = b;
                frame_xor = frame_xor ^ b;
                fill_pos  = fill_pos + 6'd1;
                if (fill_pos >= frame_len)
                    parse_state = frc_pkg::ST_CHECK;
            end
            frc_pkg::ST_CHECK: begin
                if (b == frame_xor) begin
                    // servo wins when both settings match
                    if (frame_id == cur_servo_id && frame_len == cur_servo_len) begin
                        found = 1'b1;
                        kind  = frc_pkg::KIND_SERVO;
                    end else if (frame_id == cur_relay_id && frame_len == cur_relay_len) begin
                        found = 1'b1;
                        kind  = frc_pkg::KIND_RELAY;
                    end
                end
                if (found) begin
                    run_len = int'(frame_len);
                    if (run_len > frc_pkg::MAX_RUN)
                        run_len = frc_pkg::MAX_RUN;
                    if (run_len > DEPTH)
                        run_len = DEPTH;
                    for (int i = 0; i < run_len; i++) begin
                        r.kind = kind;
                        r.data = frame_store[i[IDX_BITS-1:0]];
                        r.pos  = i[frc_pkg::POS_W-1:0];
                        r.last = (i == run_len - 1);
                        expected_payload.push_back(r);
                    end
                end
                parse_state = frc_pkg::ST_HUNT;
            end
            default: parse_state = frc_pkg::ST_HUNT;
        endcase
    endtask

    // Sender: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
                bytes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= pending_bytes.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 15) == 0)
                            gap_left = 30;
                        else
                            gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus long hold-offs while bytes are still offered
    rx_pattern_t stall_mode   = RX_STEADY;
    int          mode_left    = 0;
    int          hold_left    = 0;
    int          holds_done   = 0;
    int          next_hold_at = 200;
    int          cycle_no     = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            cycle_no++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_done < 2 && m_valid && cycle_no > next_hold_at &&
                         pending_bytes.size() > 2) begin
                hold_left    = HOLD_CYCLES;
                holds_done++;
                next_hold_at = cycle_no + 2000;
                m_ready      <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = rx_pattern_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    RX_STEADY:      m_ready <= 1'b1;
                    RX_COIN:        m_ready <= 1'($urandom_range(0, 1));
                    RX_ONE_IN_FOUR: m_ready <= (cycle_no % 4 == 0);
                    default:        m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Result checking against the oldest owed payload byte
    always @(posedge aclk) begin
        payload_result_t got;
        payload_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.kind = m_frame_kind;
            got.data = m_payload_byte;
            got.pos  = m_byte_position;
            got.last = m_last_byte;
            if (expected_payload.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h pos %0d last %0d",
                                          got.kind, got.data, got.pos, got.last));
            end else begin
                want = expected_payload.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.pos !== want.pos || got.last !== want.last)
                    report_mismatch($sformatf(
                        "result %0d: kind %0d/%0d byte %02h/%02h pos %0d/%0d last %0d/%0d",
                        results_seen, got.kind, want.kind, got.data, want.data,
                        got.pos, want.pos, got.last, want.last));
            end
            results_seen++;
            if (got.last === 1'b1)
                frames_seen++;
        end
    end

    // Register write, called at a rising edge; the caller lowers cfg_valid afterwards
    task automatic write_register(input logic [frc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            frc_pkg::REG_START_BYTE:   cur_start     = value;
            frc_pkg::REG_SERVO_ID:     cur_servo_id  = value;
            frc_pkg::REG_SERVO_LENGTH: cur_servo_len = value[5:0];
            frc_pkg::REG_RELAY_ID:     cur_relay_id  = value;
            frc_pkg::REG_RELAY_LENGTH: cur_relay_len = value[5:0];
            default: ;
        endcase
    endtask

    // Full register setting, with junk in the spare length bits and the unused indexes
    task automatic apply_setting(input logic [7:0] start, input logic [7:0] sid,
                                 input logic [5:0] slen, input logic [7:0] rid,
                                 input logic [5:0] rlen);
        logic [1:0]                    top;
        logic [frc_pkg::CFG_IDX_W-1:0] idx;
        write_register(frc_pkg::REG_START_BYTE, start);
        write_register(frc_pkg::REG_SERVO_ID, sid);
        top = 2'($urandom_range(0, 3));
        write_register(frc_pkg::REG_SERVO_LENGTH, {top, slen});
        write_register(frc_pkg::REG_RELAY_ID, rid);
        top = 2'($urandom_range(0, 3));
        write_register(frc_pkg::REG_RELAY_LENGTH, {top, rlen});
        for (int k = frc_pkg::REG_RELAY_LENGTH + 1; k < (1 << frc_pkg::CFG_IDX_W); k++) begin
            idx = k[frc_pkg::CFG_IDX_W-1:0];
            write_register(idx, 8'($urandom_range(0, 255)));
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly short payloads, now and then a full buffer
    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return DEPTH;
        return $urandom_range(1, 8);
    endfunction

    // One frame with random payload; a length byte out of range sends the header only
    task automatic queue_frame(input logic [7:0] id, input logic [7:0] len_byte,
                               input logic corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] flip;
        pending_bytes.push_back(cur_start);
        pending_bytes.push_back(id);
        pending_bytes.push_back(len_byte);
        if (len_byte != 8'd0 && int'(len_byte) <= DEPTH) begin
            sum = '0;
            for (int i = 0; i < len_byte; i++) begin
                b = 8'($urandom_range(0, 255));
                pending_bytes.push_back(b);
                sum = sum ^ b;
            end
            if (corrupt) begin
                flip = 8'($urandom_range(1, 255));
                sum  = sum ^ flip;
            end
            pending_bytes.push_back(sum);
        end
    endtask

    // Random frame mix: mostly well-formed, some broken, some noise
    task automatic queue_random_frame();
        int         pick;
        int         slen;
        int         rlen;
        logic [7:0] len_byte;
        pick = $urandom_range(0, 99);
        slen = (cur_servo_len != 0 && cur_servo_len <= DEPTH) ? cur_servo_len : pick_len();
        rlen = (cur_relay_len != 0 && cur_relay_len <= DEPTH) ? cur_relay_len : pick_len();
        if (pick < 35) begin
            queue_frame(cur_servo_id, 8'(slen), 1'b0);
        end else if (pick < 65) begin
            queue_frame(cur_relay_id, 8'(rlen), 1'b0);
        end else if (pick < 75) begin
            if (pick < 70)
                queue_frame(cur_servo_id, 8'(slen), 1'b1);
            else
                queue_frame(cur_relay_id, 8'(rlen), 1'b1);
        end else if (pick < 85) begin
            queue_frame(8'($urandom_range(0, 255)), 8'(pick_len()),
                        1'($urandom_range(0, 1)));
        end else if (pick < 92) begin
            len_byte = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(DEPTH + 1, 255));
            queue_frame(8'($urandom_range(0, 255)), len_byte, 1'b0);
        end else begin
            repeat ($urandom_range(1, 4))
                pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Wait until every request is taken and every payload byte has come back
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_payload.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Drain, then push filler until the parser is back to hunting
    task automatic finish_phase();
        wait_idle();
        while (parse_state != frc_pkg::ST_HUNT) begin
            pending_bytes.push_back(8'h00);
            wait_idle();
        end
    endtask

    // Main sequence
    initial begin
        int         phase_no;
        int         mark;
        logic [7:0] shared_id;
        for (int i = 0; i < DEPTH; i++)
            frame_store[i[IDX_BITS-1:0]] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed stream on the reset settings
        foreach (directed_bytes[i])
            pending_bytes.push_back(directed_bytes[i]);
        finish_phase();

        // random phases, each under its own register setting
        phase_no = 1;
        while (random_bytes < RANDOM_BYTES && phase_no < MAX_PHASES) begin
            case (phase_no)
                1: apply_setting(8'h00, 8'h00, 6'd32, 8'hFF, 6'd1);
                2: apply_setting(8'hFF, 8'hFF, 6'd1, 8'h00, 6'd32);
                3: begin
                    // identical servo and relay settings
                    shared_id = 8'($urandom_range(0, 255));
                    apply_setting(8'($urandom_range(0, 255)), shared_id, 6'd3, shared_id, 6'd3);
                end
                4: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 6'd0,
                                 8'($urandom_range(0, 255)), 6'd63);
                default: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       6'(pick_len()), 8'($urandom_range(0, 255)),
                                       6'(pick_len()));
            endcase
            mark = pending_bytes.size();
            while (pending_bytes.size() - mark < PHASE_BYTES)
                queue_random_frame();
            random_bytes += pending_bytes.size() - mark;
            finish_phase();
            phase_no++;
        end

        wait_idle();
        if (expected_payload.size() != 0)
            report_mismatch($sformatf("%0d payload bytes never arrived",
                                      expected_payload.size()));
        $display("covered: %0d bytes taken under %0d register settings",
                 bytes_accepted, settings_used);
        $display("covered: %0d frames accepted, %0d payload bytes checked, %0d mismatches",
                 frames_seen, results_seen, error_count);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

endmodule
